/* rtl/core/sfr_pkg.sv */
// Shared types and constants of the stream find-and-replace block.
package sfr_pkg;

  localparam int ListLen   = 8;
  localparam int CntW      = 4;
  localparam int CfgIdxW   = 4;
  localparam int EmitDepth = ListLen + 1;
  localparam int EmitCntW  = $clog2(EmitDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgPattern = 4'd0,
    CfgPatLen  = 4'd1,
    CfgRepl    = 4'd2,
    CfgReplLen = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  pat_len;
    logic [63:0] repl;
    logic [3:0]  repl_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } entry_t;

  typedef struct packed {
    entry_t [ListLen-1:0] ent;
    logic [CntW-1:0]      count;
  } res_list_t;

endpackage

/* rtl/core/stream_find_replace_top.sv */
// Top level of the stream find-and-replace block.
// Takes one source byte per request and replaces every leftmost, non-overlapping match of
// the configured pattern (1 to MaxPattern bytes) with the replacement (0 to 8 bytes). A
// request is taken whenever the output chain holds at most one result, so a stream that
// yields at most one result per byte runs at one byte per cycle while the sink is ready. A
// request that yields k results (replacement or tail flush on the last byte) loads them into
// the output chain, which emits them one at a time, and holds the source side until at most
// one is left. Config writes never stall; writing the pattern length drops pending bytes.
module stream_find_replace_top import sfr_pkg::*; #(
  parameter int MaxPattern = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               src_valid_i,
  output logic               src_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output logic               dst_valid_o,
  input  logic               dst_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_valid_o,
  output logic               out_last_o
);

  cfg_t      cfg_q, cfg_d;
  res_list_t list;
  entry_t    head;
  logic      cfg_we, clear, accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = src_valid_i && src_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    clear = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPattern: cfg_d.pattern = cfg_data_i;
        CfgPatLen: begin
          cfg_d.pat_len = cfg_data_i[3:0];
          clear         = 1'b1;
        end
        CfgRepl:    cfg_d.repl     = cfg_data_i;
        CfgReplLen: cfg_d.repl_len = cfg_data_i[3:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern  <= '0;
      cfg_q.pat_len  <= 4'd1;
      cfg_q.repl     <= '0;
      cfg_q.repl_len <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfr_window #(.MaxPattern(MaxPattern)) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .clear_i   (clear),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .list_o    (list)
  );

  sfr_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && (list.count != '0)),
    .list_i     (list),
    .ready_i    (dst_ready_i),
    .valid_o    (dst_valid_o),
    .head_o     (head),
    .in_ready_o (src_ready_o)
  );

  assign out_byte_o  = head.data;
  assign out_valid_o = head.valid;
  assign out_last_o  = head.last;

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dst_valid_o && !out_valid_o) |-> out_last_o)
    else $error("end marker without last flag");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> dst_valid_o)
    else $error("last request produced no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dst_valid_o |-> src_ready_o)
    else $error("empty output chain refuses a request");

endmodule

/* rtl/core/sfr_cell.sv */
// One storage cell of a chain: load, take the neighbour's value, or hold.
module sfr_cell #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             shift_en_i,
  input  logic [Width-1:0] shift_data_i,
  input  logic             load_en_i,
  input  logic [Width-1:0] load_data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_en_i) begin
      data_d = load_data_i;
    end else if (shift_en_i) begin
      data_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/core/sfr_window.sv */
// Pending-byte window chain, pattern compare and per-request result list.
module sfr_window import sfr_pkg::*; #(
  parameter int MaxPattern = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       clear_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output res_list_t  list_o
);

  localparam int WinDepth = (MaxPattern > 1) ? MaxPattern - 1 : 1;
  localparam int FillW    = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int PlW      = $clog2(MaxPattern + 1);

  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       win [WinDepth];
  logic [7:0]       buf_b [MaxPattern];
  logic [MaxPattern-1:0] eq;
  logic [PlW-1:0]   plen;
  logic [CntW-1:0]  rlen;
  logic [CntW-1:0]  count;
  logic             full, match, marker;

  always_comb begin
    if (cfg_i.pat_len == 4'd0) begin
      plen = PlW'(1);
    end else if (cfg_i.pat_len > 4'(MaxPattern)) begin
      plen = PlW'(MaxPattern);
    end else begin
      plen = PlW'(cfg_i.pat_len);
    end
    if (cfg_i.repl_len > 4'(ListLen)) begin
      rlen = CntW'(ListLen);
    end else begin
      rlen = CntW'(cfg_i.repl_len);
    end
  end

  for (genvar k = 0; k < MaxPattern; k++) begin : g_buf
    if ((MaxPattern > 1) && (k < WinDepth)) begin : g_win
      assign buf_b[k] = (FillW'(k) < fill_q) ? win[k] : in_byte_i;
    end else begin : g_new
      assign buf_b[k] = in_byte_i;
    end
    assign eq[k] = (PlW'(k) >= plen) || (buf_b[k] == cfg_i.pattern[8*k +: 8]);
  end

  assign full  = (PlW'(fill_q) + PlW'(1)) == plen;
  assign match = full && (&eq);

  always_comb begin
    marker = 1'b0;
    if (match) begin
      if (in_last_i && (rlen == '0)) begin
        count  = CntW'(1);
        marker = 1'b1;
      end else begin
        count = rlen;
      end
    end else if (full) begin
      count = in_last_i ? CntW'(plen) : CntW'(1);
    end else begin
      count = in_last_i ? (CntW'(fill_q) + CntW'(1)) : '0;
    end
  end

  for (genvar k = 0; k < ListLen; k++) begin : g_list
    logic [7:0] src;
    if (k < MaxPattern) begin : g_src
      assign src = buf_b[k];
    end else begin : g_zero
      assign src = 8'h00;
    end
    assign list_o.ent[k].data  = marker ? 8'h00 : (match ? cfg_i.repl[8*k +: 8] : src);
    assign list_o.ent[k].valid = !marker;
    assign list_o.ent[k].last  = in_last_i && (CntW'(k) == (count - CntW'(1)));
  end
  assign list_o.count = count;

  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    logic [7:0] sh;
    if (i + 1 < MaxPattern) begin : g_sh
      assign sh = buf_b[i+1];
    end else begin : g_shn
      assign sh = in_byte_i;
    end
    sfr_cell #(.Width(8)) u_cell (
      .clk_i        (clk_i),
      .shift_en_i   (accept_i && full),
      .shift_data_i (sh),
      .load_en_i    (accept_i && !full && (fill_q == FillW'(i))),
      .load_data_i  (in_byte_i),
      .data_o       (win[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (clear_i) begin
      fill_d = '0;
    end else if (accept_i) begin
      if (match || in_last_i) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

/* rtl/core/sfr_emitter.sv */
// Output chain of result cells, drained one result per cycle while the receiver is ready.
module sfr_emitter import sfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_list_t list_i,
  input  logic      ready_i,
  output logic      valid_o,
  output entry_t    head_o,
  output logic      in_ready_o
);

  localparam int EntW = $bits(entry_t);

  logic [EmitCntW-1:0] cnt_q, cnt_d;
  logic [EntW-1:0]     chain [EmitDepth];
  logic                pop, base_one;

  assign valid_o    = cnt_q != '0;
  assign pop        = valid_o && ready_i;
  assign in_ready_o = cnt_q <= EmitCntW'(1);
  assign base_one   = (cnt_q == EmitCntW'(1)) && !pop;
  assign head_o     = entry_t'(chain[0]);

  for (genvar i = 0; i < EmitDepth; i++) begin : g_cell
    logic [EntW-1:0] lo_ent, hi_ent, sh;
    logic            lo_hit, hi_hit;
    if (i < ListLen) begin : g_lo
      assign lo_ent = list_i.ent[i];
      assign lo_hit = CntW'(i) < list_i.count;
    end else begin : g_lon
      assign lo_ent = '0;
      assign lo_hit = 1'b0;
    end
    if (i >= 1) begin : g_hi
      assign hi_ent = list_i.ent[i-1];
      assign hi_hit = CntW'(i - 1) < list_i.count;
    end else begin : g_hin
      assign hi_ent = '0;
      assign hi_hit = 1'b0;
    end
    if (i + 1 < EmitDepth) begin : g_sh
      assign sh = chain[i+1];
    end else begin : g_shn
      assign sh = chain[i];
    end
    sfr_cell #(.Width(EntW)) u_cell (
      .clk_i        (clk_i),
      .shift_en_i   (pop),
      .shift_data_i (sh),
      .load_en_i    (load_i && (base_one ? hi_hit : lo_hit)),
      .load_data_i  (base_one ? hi_ent : lo_ent),
      .data_o       (chain[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q - EmitCntW'(pop);
    if (load_i) begin
      cnt_d = cnt_d + EmitCntW'(list_i.count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sim/stream_find_replace_checker.sv */
`timescale 1ns / 1ps
// Checker: predicts the rewritten byte stream and compares it with what the block emits.
module stream_find_replace_checker import sfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               src_valid_i,
  input  logic               src_ready_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  logic               dst_valid_i,
  input  logic               dst_ready_i,
  input  logic [7:0]         out_byte_i,
  input  logic               out_valid_i,
  input  logic               out_last_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);

  logic [63:0] pattern_q;
  logic [3:0]  pat_len_q;
  logic [63:0] repl_q;
  logic [3:0]  repl_len_q;
  logic [7:0]  window_q [ListLen-1];
  int unsigned fill_q;
  entry_t      expected_bytes_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic predict_rewrite(input logic [7:0] b, input logic l);
    logic [7:0]  held [ListLen];
    entry_t      fresh [$];
    int unsigned plen;
    int unsigned rlen;
    int unsigned n;
    logic        hit;
    plen = (pat_len_q == 0) ? 1 : ((pat_len_q > ListLen) ? ListLen : pat_len_q);
    rlen = (repl_len_q > ListLen) ? ListLen : repl_len_q;
    n = (fill_q > plen - 1) ? plen - 1 : fill_q;
    for (int i = 0; i < n; i++) held[i] = window_q[i];
    held[n] = b;
    n++;
    if (n >= plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (held[i] != pattern_q[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) fresh.push_back('{repl_q[8*i +: 8], 1'b1, 1'b0});
        n = 0;
      end else begin
        fresh.push_back('{held[0], 1'b1, 1'b0});
        for (int i = 1; i < n; i++) held[i-1] = held[i];
        n--;
      end
    end
    if (l) begin
      for (int i = 0; i < n; i++) fresh.push_back('{held[i], 1'b1, 1'b0});
      n = 0;
      if (fresh.size() == 0) fresh.push_back('{8'h00, 1'b0, 1'b0});
      fresh[fresh.size()-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) window_q[i] = held[i];
    fill_q = n;
    foreach (fresh[i]) expected_bytes_q.push_back(fresh[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t e;
    if (!rst_ni) begin
      pattern_q = '0;
      pat_len_q = 4'd1;
      repl_q = '0;
      repl_len_q = '0;
      fill_q = 0;
      expected_bytes_q.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPattern: pattern_q = cfg_data_i;
          CfgPatLen: begin
            pat_len_q = cfg_data_i[3:0];
            fill_q = 0;
          end
          CfgRepl:    repl_q = cfg_data_i;
          CfgReplLen: repl_len_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (src_valid_i && src_ready_i) predict_rewrite(in_byte_i, in_last_i);
      if (dst_valid_i && dst_ready_i) begin
        if (expected_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h valid %0b last %0b",
                                    out_byte_i, out_valid_i, out_last_i));
        end else begin
          e = expected_bytes_q.pop_front();
          if (out_byte_i !== e.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_i, e.data));
          if (out_valid_i !== e.valid)
            report_mismatch($sformatf("out_valid %0b, expected %0b", out_valid_i, e.valid));
          if (out_last_i !== e.last)
            report_mismatch($sformatf("out_last %0b, expected %0b", out_last_i, e.last));
        end
      end
      outstanding_o = expected_bytes_q.size();
    end
  end

endmodule

/* sim/stream_find_replace_top_test.sv */
`timescale 1ns / 1ps
// Testbench top: drives byte texts and register writes into the find-and-replace block.
module stream_find_replace_top_test;
  import sfr_pkg::*;

  localparam int StimItems    = 470;
  localparam int WatchLimit   = 2000;
  localparam int SettleCycles = 16;
  localparam int DrainCycles  = 20;

  typedef enum int {ReadyAlways, ReadyHalf, ReadyQuarter, ReadyBursty} stall_mode_e;
  typedef enum int {AlphaBinary, AlphaTriple, AlphaFull} alphabet_e;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0]        cfg_data_i  = '0;
  logic               src_valid_i = 1'b0;
  logic               src_ready_o;
  logic [7:0]         in_byte_i   = '0;
  logic               in_last_i   = 1'b0;
  logic               dst_valid_o;
  logic               dst_ready_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               out_valid_o;
  logic               out_last_o;

  int mismatches;
  int outstanding;

  int          sent;
  int          burst_left;
  int          quiet_cycles;
  stall_mode_e stall_mode = ReadyAlways;
  int          mode_left;
  int          stall_left;
  alphabet_e   alph_mode = AlphaFull;
  logic [7:0]  alph [3];
  logic [63:0] stim_pattern;
  int unsigned stim_plen = 1;

  stream_find_replace_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .src_valid_i (src_valid_i),
    .src_ready_o (src_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .dst_valid_o (dst_valid_o),
    .dst_ready_i (dst_ready_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o)
  );

  stream_find_replace_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .src_valid_i   (src_valid_i),
    .src_ready_i   (src_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .dst_valid_i   (dst_valid_o),
    .dst_ready_i   (dst_ready_i),
    .out_byte_i    (out_byte_o),
    .out_valid_i   (out_valid_o),
    .out_last_i    (out_last_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 96);
      stall_mode = stall_mode_e'($urandom_range(0, 3));
    end else begin
      mode_left--;
    end
    case (stall_mode)
      ReadyAlways:  dst_ready_i <= 1'b1;
      ReadyHalf:    dst_ready_i <= 1'($urandom_range(0, 1));
      ReadyQuarter: dst_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          dst_ready_i <= 1'b0;
        end else begin
          stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : 0;
          dst_ready_i <= (stall_left == 0);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (src_valid_i && src_ready_o) || (dst_valid_o && dst_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    case (alph_mode)
      AlphaBinary: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      AlphaTriple: return alph[$urandom_range(0, 2)];
      default:     return 8'($urandom);
    endcase
  endfunction

  // hold the source request until taken; gaps fall between bursts
  task automatic send_request(input logic [7:0] b, input logic l);
    int gap;
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        src_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    src_valid_i <= 1'b1;
    in_byte_i <= b;
    in_last_i <= l;
    @(posedge clk_i);
    while (!src_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (idx == CfgPattern) stim_pattern = data;
    if (idx == CfgPatLen)
      stim_plen = (data[3:0] == 0) ? 1 : ((data[3:0] > ListLen) ? ListLen : data[3:0]);
  endtask

  // drain every expected result, then let the block go quiet
  task automatic settle();
    src_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    wait (outstanding == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input bit first);
    logic [7:0]  text_q [$];
    logic [63:0] data;
    int          len;
    int          r;
    int          texts;
    bit          open_end;
    settle();
    alph_mode = alphabet_e'($urandom_range(0, 2));
    foreach (alph[i]) alph[i] = 8'($urandom);
    if (first || $urandom_range(0, 1)) begin
      for (int i = 0; i < ListLen; i++) data[8*i +: 8] = pick_byte();
      write_register(CfgPattern, data);
    end
    if (first || $urandom_range(0, 1)) begin
      r = $urandom_range(0, 19);
      if (r < 2) len = (r == 0) ? 0 : $urandom_range(ListLen + 1, (1 << CntW) - 1);
      else if (r < 13) len = $urandom_range(1, 3);
      else len = $urandom_range(4, ListLen);
      data = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      data[3:0] = 4'(len);
      write_register(CfgPatLen, data);
    end
    if (first || $urandom_range(0, 1)) write_register(CfgRepl, {$urandom, $urandom});
    if (first || $urandom_range(0, 1)) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << CntW) - 1)
                                         : $urandom_range(0, 3);
      data = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      data[3:0] = 4'(len);
      write_register(CfgReplLen, data);
    end
    if ($urandom_range(0, 7) == 0)
      write_register(CfgIdxW'($urandom_range(int'(CfgReplLen) + 1, (1 << CfgIdxW) - 1)),
                     {$urandom, $urandom});
    texts = $urandom_range(1, 4);
    for (int t = 0; t < texts; t++) begin
      open_end = (t == texts - 1) && ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      text_q.delete();
      while (text_q.size() < len) begin
        if ($urandom_range(0, 9) < 4) begin
          for (int i = 0; i < stim_plen; i++) text_q.push_back(stim_pattern[8*i +: 8]);
          if ($urandom_range(0, 3) == 0) text_q[$urandom_range(0, text_q.size() - 1)] = pick_byte();
        end else begin
          text_q.push_back(pick_byte());
        end
      end
      foreach (text_q[i]) send_request(text_q[i], (i == text_q.size() - 1) && !open_end);
    end
  endtask

  initial begin
    int base;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: single zero byte deleted, so a final zero leaves only the end marker
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b1);

    settle();
    write_register(CfgPattern, 64'h0000_0000_0063_6261);
    write_register(CfgPatLen, 64'd3);
    write_register(CfgRepl, 64'hFFEE_DDCC_BBAA_9988);
    write_register(CfgReplLen, 64'hF);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h63, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b1);

    settle();
    write_register(CfgPatLen, 64'hFFFF_FFFF_FFFF_FFF0);
    write_register(CfgPattern, 64'h0000_0000_0000_00FF);
    write_register(CfgReplLen, 64'h0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);

    settle();
    write_register(CfgPatLen, 64'hC);
    write_register(CfgPattern, 64'h5A5A_5A5A_5A5A_5A5A);
    write_register(CfgRepl, 64'h0);
    write_register(CfgReplLen, 64'h1);
    repeat (4) send_request(8'h5A, 1'b0);
    // drop the pending bytes mid-text
    settle();
    write_register(CfgPatLen, 64'd8);
    repeat (7) send_request(8'h5A, 1'b0);
    send_request(8'h5A, 1'b1);

    base = sent;
    run_phase(1'b1);
    while (sent < base + StimItems) run_phase(1'b0);

    src_valid_i <= 1'b0;
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
